// ===== rtl/sps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types, codes and constants of the servo pulse sequencer.
// ----------------------------------------------------------------------------
package sps_pkg;

   localparam int SLOT_COUNT           = 8;
   localparam int DEFAULT_NUM_CHANNELS = 8;
   localparam int CHAN_W               = 3;
   localparam int SLOT_W               = 4;
   localparam int TIME_W               = 16;
   localparam int SUM_W                = 17;
   localparam int PIN_W                = 8;
   localparam int STATUS_W             = 2;
   localparam int CSR_INDEX_W          = 1;
   localparam int REQ_DATA_W           = 24;
   localparam int RSP_DATA_W           = 16;

   localparam logic [SLOT_W-1:0]      COMPLEMENT_SLOT = 4'd8;
   localparam logic [TIME_W-1:0]      RESET_PERIOD    = 16'd20000;
   localparam logic [TIME_W-1:0]      RESET_TOLERANCE = 16'd10;

   localparam logic [CSR_INDEX_W-1:0] REG_PERIOD      = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_TOLERANCE   = 1'b1;

   localparam logic [STATUS_W-1:0]    STATUS_OK          = 2'd0;
   localparam logic [STATUS_W-1:0]    STATUS_NO_TIME     = 2'd1;
   localparam logic [STATUS_W-1:0]    STATUS_BAD_CHANNEL = 2'd2;

   typedef enum logic [1:0] {
      KIND_TICK   = 2'd0,
      KIND_SET    = 2'd1,
      KIND_ADD    = 2'd2,
      KIND_REMOVE = 2'd3
   } sps_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_EXEC = 2'd1,
      ST_RESP = 2'd2
   } sps_state_type;

   typedef struct packed {
      logic capture;
      logic execute;
      logic load_rsp;
   } sps_cmd_type;

   typedef struct packed {
      logic rsp_free;
   } sps_stat_type;

endpackage
`default_nettype wire

// ===== rtl/sps_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sps_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sps_ram #(
   parameter int DATA_WIDTH = 16,
   parameter int DEPTH      = 8
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  wire logic [DATA_WIDTH-1:0]         wr_data,
   input  wire logic                          rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic      [DATA_WIDTH-1:0]         rd_data
);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/sps_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sps_ctrl
// Request sequencing controller: capture, execute, respond.
// ----------------------------------------------------------------------------
module sps_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire sps_pkg::sps_stat_type stat,
   output sps_pkg::sps_cmd_type      cmd
);
   import sps_pkg::*;

   sps_state_type state_ff;
   sps_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (stat.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready   = 1'b0;
      cmd.capture  = 1'b0;
      cmd.execute  = 1'b0;
      cmd.load_rsp = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
         end
         ST_RESP: begin
            cmd.load_rsp = stat.rsp_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/sps_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sps_datapath
// Channel table, slot timer, width bookkeeping and response register.
// ----------------------------------------------------------------------------
module sps_datapath #(
   parameter int NUM_CHANNELS = sps_pkg::DEFAULT_NUM_CHANNELS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire sps_pkg::sps_cmd_type                cmd,
   output sps_pkg::sps_stat_type                    stat,
   input  wire logic [1:0]                          req_tuser,
   input  wire logic [sps_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  wire logic                                csr_wr_en,
   input  wire logic [sps_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [sps_pkg::TIME_W-1:0]          csr_wr_data,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic      [sps_pkg::RSP_DATA_W-1:0]      rsp_tdata
);
   import sps_pkg::*;

   // Architectural state.
   logic [TIME_W-1:0]     period_ff, period_in;
   logic [TIME_W-1:0]     tol_ff, tol_in;
   logic [SLOT_COUNT-1:0] present_ff, present_in;
   logic [SLOT_COUNT-1:0] nonzero_ff, nonzero_in;
   logic [TIME_W-1:0]     unres_ff, unres_in;
   logic [SUM_W-1:0]      rsum_ff, rsum_in;
   logic [SUM_W-1:0]      wsum_ff, wsum_in;
   logic [SLOT_W-1:0]     cur_ff, cur_in;
   logic [TIME_W-1:0]     rem_ff, rem_in;
   logic                  active_ff, active_in;

   // Captured request and results.
   sps_kind_type          kind_ff;
   logic [CHAN_W-1:0]     chan_ff;
   logic [TIME_W-1:0]     value_ff;
   logic [SLOT_W-1:0]     pick_ff;
   logic                  found_ff;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic [SLOT_COUNT-1:0] usable_mask;
   logic [SLOT_COUNT:0]   cand;
   logic [SLOT_W-1:0]     pick_slot;
   logic                  pick_found;
   logic [SLOT_W:0]       step_idx;
   logic [SUM_W-1:0]      period_ext;
   logic [SUM_W-1:0]      comp_diff;
   logic [TIME_W-1:0]     comp_width;
   logic [SUM_W-1:0]      comp_new_diff;
   logic [TIME_W-1:0]     comp_new;
   logic [SUM_W-1:0]      cfg_ext;
   logic [SUM_W-1:0]      cfg_diff;
   logic [SUM_W-1:0]      unres_sum;
   logic [TIME_W-1:0]     clamp_w;
   logic [TIME_W-1:0]     set_w;
   logic                  run_update;
   logic                  want;
   logic [PIN_W-1:0]      pins;

   logic [CHAN_W-1:0]     rd_addr;
   logic [TIME_W-1:0]     rd_width;
   logic [TIME_W-1:0]     rd_max;
   logic                  wram_we;
   logic [TIME_W-1:0]     wram_data;
   logic                  mram_we;

   always_comb begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         usable_mask[i] = (i < NUM_CHANNELS);
      end
   end

   assign period_ext = {1'b0, period_ff};
   assign comp_diff  = period_ext - wsum_ff;
   assign comp_width = (wsum_ff >= period_ext) ? '0 : comp_diff[TIME_W-1:0];

   // Rotating pick of the next slot after the current one.
   always_comb begin
      cand       = {(comp_width != '0), nonzero_ff};
      pick_slot  = COMPLEMENT_SLOT;
      pick_found = 1'b0;
      step_idx   = '0;
      for (int i = 1; i <= SLOT_COUNT + 1; i++) begin
         step_idx = {1'b0, cur_ff} + (SLOT_W + 1)'(i);
         if (step_idx > (SLOT_W + 1)'(SLOT_COUNT)) begin
            step_idx = step_idx - (SLOT_W + 1)'(SLOT_COUNT + 1);
         end
         if (!pick_found && cand[step_idx[SLOT_W-1:0]]) begin
            pick_slot  = step_idx[SLOT_W-1:0];
            pick_found = 1'b1;
         end
      end
   end

   assign rd_addr = (req_tuser == KIND_TICK) ? pick_slot[CHAN_W-1:0]
                                             : req_tdata[CHAN_W-1:0];

   sps_ram #(
      .DATA_WIDTH (TIME_W),
      .DEPTH      (SLOT_COUNT)
   ) u_width_ram (
      .clock   (clock),
      .wr_en   (wram_we),
      .wr_addr (chan_ff),
      .wr_data (wram_data),
      .rd_en   (cmd.capture),
      .rd_addr (rd_addr),
      .rd_data (rd_width)
   );

   sps_ram #(
      .DATA_WIDTH (TIME_W),
      .DEPTH      (SLOT_COUNT)
   ) u_max_ram (
      .clock   (clock),
      .wr_en   (mram_we),
      .wr_addr (chan_ff),
      .wr_data (value_ff),
      .rd_en   (cmd.capture),
      .rd_addr (rd_addr),
      .rd_data (rd_max)
   );

   assign clamp_w   = (value_ff > rd_max) ? rd_max : value_ff;
   assign set_w     = (clamp_w < tol_ff) ? '0 : clamp_w;
   assign unres_sum = {1'b0, unres_ff} + {1'b0, rd_max};
   assign cfg_ext   = {1'b0, csr_wr_data};
   assign cfg_diff  = cfg_ext - rsum_ff;

   always_comb begin
      period_in  = period_ff;
      tol_in     = tol_ff;
      present_in = present_ff;
      nonzero_in = nonzero_ff;
      unres_in   = unres_ff;
      rsum_in    = rsum_ff;
      wsum_in    = wsum_ff;
      cur_in     = cur_ff;
      rem_in     = rem_ff;
      active_in  = active_ff;
      status_in  = status_ff;
      wram_we    = 1'b0;
      wram_data  = '0;
      mram_we    = 1'b0;
      run_update = 1'b0;

      if (cmd.execute) begin
         status_in = STATUS_OK;
         unique case (kind_ff)
            KIND_TICK: begin
               if (active_ff) begin
                  if (rem_ff > 16'd1) begin
                     rem_in = rem_ff - 16'd1;
                  end else if (found_ff) begin
                     cur_in = pick_ff;
                     rem_in = (pick_ff == COMPLEMENT_SLOT) ? comp_width : rd_width;
                  end else begin
                     cur_in = COMPLEMENT_SLOT;
                     rem_in = '0;
                  end
               end
            end
            KIND_SET: begin
               if (!usable_mask[chan_ff] || !present_ff[chan_ff]) begin
                  status_in = STATUS_BAD_CHANNEL;
               end else begin
                  wram_we             = 1'b1;
                  wram_data           = set_w;
                  wsum_in             = wsum_ff - {1'b0, rd_width} + {1'b0, set_w};
                  nonzero_in[chan_ff] = (set_w != '0);
                  run_update          = 1'b1;
               end
            end
            KIND_ADD: begin
               if (!usable_mask[chan_ff] || present_ff[chan_ff]) begin
                  status_in = STATUS_BAD_CHANNEL;
               end else if (value_ff > unres_ff) begin
                  status_in = STATUS_NO_TIME;
               end else begin
                  present_in[chan_ff] = 1'b1;
                  mram_we             = 1'b1;
                  wram_we             = 1'b1;
                  wram_data           = '0;
                  unres_in            = unres_ff - value_ff;
                  rsum_in             = rsum_ff + {1'b0, value_ff};
               end
            end
            KIND_REMOVE: begin
               if (!usable_mask[chan_ff] || !present_ff[chan_ff]) begin
                  status_in = STATUS_BAD_CHANNEL;
               end else begin
                  unres_in = (unres_sum > {1'b0, 16'hFFFF}) ? 16'hFFFF
                                                           : unres_sum[TIME_W-1:0];
                  rsum_in             = rsum_ff - {1'b0, rd_max};
                  wsum_in             = wsum_ff - {1'b0, rd_width};
                  present_in[chan_ff] = 1'b0;
                  nonzero_in[chan_ff] = 1'b0;
                  if (active_ff && (cur_ff == {1'b0, chan_ff})) begin
                     rem_in = '0;
                  end
                  run_update = 1'b1;
               end
            end
            default: begin
               status_in = STATUS_OK;
            end
         endcase
      end

      comp_new_diff = period_ext - wsum_in;
      comp_new      = (wsum_in >= period_ext) ? '0 : comp_new_diff[TIME_W-1:0];
      want          = |nonzero_in;
      if (run_update) begin
         if (!active_ff && want) begin
            active_in = 1'b1;
            cur_in    = COMPLEMENT_SLOT;
            rem_in    = comp_new;
         end else if (active_ff && !want) begin
            active_in = 1'b0;
            cur_in    = COMPLEMENT_SLOT;
            rem_in    = '0;
         end
      end

      if (csr_wr_en) begin
         unique case (csr_index)
            REG_PERIOD: begin
               period_in = csr_wr_data;
               unres_in  = (rsum_ff >= cfg_ext) ? '0 : cfg_diff[TIME_W-1:0];
            end
            REG_TOLERANCE: begin
               tol_in = csr_wr_data;
            end
            default: begin
               tol_in = tol_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= RESET_PERIOD;
         tol_ff       <= RESET_TOLERANCE;
         present_ff   <= '0;
         nonzero_ff   <= '0;
         unres_ff     <= RESET_PERIOD;
         rsum_ff      <= '0;
         wsum_ff      <= '0;
         cur_ff       <= COMPLEMENT_SLOT;
         rem_ff       <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         period_ff    <= period_in;
         tol_ff       <= tol_in;
         present_ff   <= present_in;
         nonzero_ff   <= nonzero_in;
         unres_ff     <= unres_in;
         rsum_ff      <= rsum_in;
         wsum_ff      <= wsum_in;
         cur_ff       <= cur_in;
         rem_ff       <= rem_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= sps_kind_type'(req_tuser);
         chan_ff  <= req_tdata[CHAN_W-1:0];
         value_ff <= req_tdata[CHAN_W+TIME_W-1:CHAN_W];
         pick_ff  <= pick_slot;
         found_ff <= pick_found;
      end
      status_ff <= status_in;
      if (cmd.load_rsp) begin
         rsp_data_ff <= {1'b0, active_ff, status_ff, cur_ff, pins};
      end
   end

   always_comb begin
      pins = '0;
      if (active_ff && (cur_ff != COMPLEMENT_SLOT) && present_ff[cur_ff[CHAN_W-1:0]]) begin
         pins = PIN_W'(1) << cur_ff[CHAN_W-1:0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign stat.rsp_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_tdata     = rsp_data_ff;

   // The sequencer runs exactly while some channel holds a nonzero width.
   a_active_tracks_widths: assert property (@(posedge clock) disable iff (reset)
      active_ff == (|nonzero_ff))
      else $error("run flag disagrees with channel widths");

   a_idle_parked: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> (cur_ff == COMPLEMENT_SLOT && rem_ff == '0))
      else $error("idle sequencer not parked in complement slot");

   a_nonzero_present: assert property (@(posedge clock) disable iff (reset)
      (nonzero_ff & ~present_ff) == '0)
      else $error("nonzero width on an absent channel");

   a_pins_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0(rsp_data_ff[PIN_W-1:0]))
      else $error("more than one servo pin high");

endmodule
`default_nettype wire

// ===== rtl/servo_pulse_sequencer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// servo_pulse_sequencer
// Multiplexed servo pulse sequencer driven by microsecond ticks and commands.
// ----------------------------------------------------------------------------
// Each request (tick, set, add or remove) passes through the controller states
// in order. In IDLE it is accepted and captured and the channel width tables
// are read; in EXEC, the next cycle, the state is updated; in RESP the
// response is loaded into the output register once the previous response
// has been taken. The three-state controller around the registered-read
// width tables sets this order, so a new request is taken only once the block
// is back in IDLE, and later when the previous response has not been taken yet.
// One request yields exactly one response. Configuration writes take effect at
// once; the user must make them only while idle, the block does not enforce it.
// ----------------------------------------------------------------------------
module servo_pulse_sequencer #(
   parameter int NUM_CHANNELS = sps_pkg::DEFAULT_NUM_CHANNELS
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // kind [1:0]
   input  wire logic [1:0]                       req_tuser,
   // channel [2:0], value [18:3], zero fill [23:19]
   input  wire logic [sps_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // pin_levels [7:0], active_slot [11:8], status [13:12], running [14],
   // zero fill [15]
   output logic      [sps_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  wire logic                             csr_wr_en,
   input  wire logic [sps_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [sps_pkg::TIME_W-1:0]       csr_wr_data
);
   import sps_pkg::*;

   sps_cmd_type  cmd;
   sps_stat_type stat;

   sps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   sps_datapath #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule
`default_nettype wire
